// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SKE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define SKE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ske_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman estimator package
// Field widths, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package ske_pkg;

    // Field and datapath widths.
    localparam int MEAS_W      = 16;  // integer measurement
    localparam int FRAC_W      = 16;  // fraction bits of Q16.16
    localparam int FIX_W       = 32;  // Q16.16 estimate and errors
    localparam int SUM_W       = 33;  // sum of two errors
    localparam int GAIN_W      = 17;  // Q1.16 gain, 0 to 1.0 inclusive
    localparam int Q_W         = 24;  // Q8.16 process noise
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_TDATA_W = 104;

    // Fixed-point constants.
    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0]       HALF_Q16 = 16'h8000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;

    // Register reset values.
    localparam logic [FIX_W-1:0] MEAS_ERR_RST   = 32'd4194304;
    localparam logic [FIX_W-1:0] INIT_ERR_RST   = 32'd4194304;
    localparam logic [Q_W-1:0]   PROC_NOISE_RST = 24'd65536;

endpackage

// ===== rtl/core/ske_serial_divider.sv =====
// ----------------------------------------------------------------------------
// Serial gain divider
// Restoring divider, one quotient bit per cycle: floor(e * 2^16 / s).
// ----------------------------------------------------------------------------
module ske_serial_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ske_pkg::FIX_W-1:0]    dividend,
    input  logic [ske_pkg::SUM_W-1:0]    divisor,
    output logic                         done,
    output logic [ske_pkg::GAIN_W-1:0]   quotient
);
    import ske_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  div_reg;
    logic [GAIN_W-1:0] shin_reg;
    logic [GAIN_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [SUM_W:0]    trial;
    logic              fits;
    logic [SUM_W:0]    trial_diff;

    // The quotient never exceeds 2^16, so the top dividend bits start in the
    // remainder and only the last GAIN_W bits are shifted in.
    always_comb
    begin
        trial      = {rem_reg, shin_reg[GAIN_W-1]};
        fits       = (trial >= {1'b0, div_reg});
        trial_diff = trial - {1'b0, div_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(GAIN_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, dividend[FIX_W-1:1]};
            div_reg  <= divisor;
            shin_reg <= {dividend[0], {(GAIN_W-1){1'b0}}};
            quo_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            shin_reg <= {shin_reg[GAIN_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[GAIN_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/ske_serial_multiplier.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ske_serial_multiplier #(
    parameter int A_W = ske_pkg::FIX_W,
    parameter int B_W = ske_pkg::Q_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     multiplicand,
    input  logic [B_W-1:0]     multiplier,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);
    import ske_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [P_W-1:0]   acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [A_W-1:0]   addend;
    logic [A_W:0]     partial;

    // Add the multiplicand into the upper half when the current bit is set.
    always_comb
    begin
        addend  = b_reg[0] ? a_reg : '0;
        partial = {1'b0, acc_reg[P_W-1:B_W]} + {1'b0, addend};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(B_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Operand and accumulator shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= multiplicand;
            b_reg   <= multiplier;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            b_reg   <= {1'b0, b_reg[B_W-1:1]};
            acc_reg <= {partial, acc_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/scalar_kalman_estimator_unit.sv =====
// Sequence: an accepted input beat runs the 17-step serial divider, skipped when
// the summed error is zero, then the two 17-bit shift-add multiplies side by side,
// then the one 24-bit multiply; a new input beat is taken only back in idle.
// Reset: asynchronous, active low; configuration registers take their defaults, the next
// measurement seeds the estimate and no result beat is pending.
// ----------------------------------------------------------------------------
// Scalar Kalman estimator unit
// Fixed-point scalar Kalman filter with bit-serial divide and multiply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_estimator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [ske_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ske_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] measurement
    input  logic [0:0]                       s_tuser,   // [0] restart
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] estimate_rounded, [47:16] estimate_full, [64:48] gain,
    // [96:65] estimate_error_out, [103:97] zero
    output logic [ske_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import ske_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_DIVS = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MULS = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_CHG  = 4'd6;
    localparam logic [3:0] S_QS   = 4'd7;
    localparam logic [3:0] S_Q    = 4'd8;
    localparam logic [3:0] S_ERR  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    localparam int P1_W = FIX_W + GAIN_W;
    localparam int P3_W = FIX_W + Q_W;
    localparam int T2_W = P3_W - FRAC_W + 1;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;

    // Configuration registers.
    logic [FIX_W-1:0]   r_reg;
    logic [FIX_W-1:0]   e0_reg;
    logic [Q_W-1:0]     q_reg;

    // Filter state.
    logic               first_reg;
    logic [FIX_W-1:0]   last_reg;
    logic [FIX_W-1:0]   err_reg;

    // Working registers of one update.
    logic [FIX_W-1:0]   meas_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [FIX_W-1:0]   diff_reg;
    logic               neg_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [FIX_W-1:0]   change_reg;
    logic [FIX_W-1:0]   t1_reg;
    logic [FIX_W-1:0]   est_reg;
    logic [T2_W-1:0]    t2_reg;

    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic               in_beat;
    logic               out_free;
    logic [FIX_W-1:0]   meas_q;

    logic               div_start;
    logic               div_done;
    logic [GAIN_W-1:0]  div_quo;
    logic               mul_start;
    logic               mul_done;
    logic               mul_err_done;
    logic [P1_W-1:0]    p_diff;
    logic [P1_W-1:0]    p_err;
    logic               q_start;
    logic               q_done;
    logic [P3_W-1:0]    p_q;

    logic [P1_W-1:0]    change_sum;
    logic [P1_W-1:0]    t1_sum;
    logic [P3_W:0]      t2_sum;
    logic [T2_W:0]      err_sum;
    logic [FIX_W-1:0]   err_next;
    logic [FIX_W:0]     rnd_sum;
    logic [MEAS_W-1:0]  rnd;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign meas_q   = {s_tdata[MEAS_W-1:0], {FRAC_W{1'b0}}};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_beat) state_next = S_SUM;
            S_SUM:  state_next = S_DIVS;
            S_DIVS: state_next = (sum_reg == '0) ? S_MULS : S_DIV;
            S_DIV:  if (div_done) state_next = S_MULS;
            S_MULS: state_next = S_MUL;
            S_MUL:  if (mul_done) state_next = S_CHG;
            S_CHG:  state_next = S_QS;
            S_QS:   state_next = S_Q;
            S_Q:    if (q_done) state_next = S_ERR;
            S_ERR:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign div_start = (state_reg == S_DIVS) && (sum_reg != '0);
    assign mul_start = (state_reg == S_MULS);
    assign q_start   = (state_reg == S_QS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg  <= MEAS_ERR_RST;
            e0_reg <= INIT_ERR_RST;
            q_reg  <= PROC_NOISE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MEAS_ERR:   r_reg  <= cfg_wdata;
                REG_INIT_ERR:   e0_reg <= cfg_wdata;
                REG_PROC_NOISE: q_reg  <= cfg_wdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    // Filter state: seeding on the first or a restart beat, update at the end of a step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            last_reg  <= '0;
            err_reg   <= INIT_ERR_RST;
        end
        else if (in_beat)
        begin
            first_reg <= 1'b0;
            if (first_reg || s_tuser[0])
            begin
                last_reg <= meas_q;
                err_reg  <= e0_reg;
            end
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            last_reg <= est_reg;
            err_reg  <= err_next;
        end
    end

    // Rounding of the products and the estimate, and the saturating error sum.
    always_comb
    begin
        change_sum = p_diff + P1_W'(neg_reg ? {1'b0, HALF_Q16 - 16'd1} : {1'b0, HALF_Q16});
        t1_sum     = p_err + P1_W'(HALF_Q16);
        t2_sum     = {1'b0, p_q} + (P3_W + 1)'(HALF_Q16);
        err_sum    = {1'b0, t2_reg} + (T2_W + 1)'(t1_reg);
        err_next   = (err_sum[T2_W:FIX_W] != '0) ? {FIX_W{1'b1}} : err_sum[FIX_W-1:0];
        rnd_sum    = {1'b0, est_reg} + (FIX_W + 1)'(HALF_Q16);
        rnd        = rnd_sum[FIX_W] ? {MEAS_W{1'b1}} : rnd_sum[FIX_W-1:FRAC_W];
    end

    // Working registers of the update.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            meas_reg <= meas_q;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= {1'b0, err_reg} + {1'b0, r_reg};
            if (meas_reg >= last_reg)
            begin
                diff_reg <= meas_reg - last_reg;
                neg_reg  <= 1'b0;
            end
            else
            begin
                diff_reg <= last_reg - meas_reg;
                neg_reg  <= 1'b1;
            end
        end
        if (state_reg == S_DIVS)
        begin
            gain_reg <= '0;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            gain_reg <= div_quo;
        end
        if (state_reg == S_CHG)
        begin
            change_reg <= change_sum[P1_W-2:FRAC_W];
            t1_reg     <= t1_sum[P1_W-2:FRAC_W];
        end
        if (state_reg == S_QS)
        begin
            est_reg <= neg_reg ? (last_reg - change_reg) : (last_reg + change_reg);
        end
        if (state_reg == S_ERR)
        begin
            t2_reg <= t2_sum[P3_W:FRAC_W];
        end
    end

    // Output register toward the result stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            m_tdata_reg <= {7'b0, err_next, gain_reg, est_reg, rnd};
        end
    end

    // Gain divider.
    ske_serial_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (err_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Gain times the innovation.
    ske_serial_multiplier #(
        .A_W (FIX_W),
        .B_W (GAIN_W)
    ) u_mul_diff (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (diff_reg),
        .multiplier   (gain_reg),
        .done         (mul_done),
        .product      (p_diff)
    );

    // One minus gain times the prior error.
    ske_serial_multiplier #(
        .A_W (FIX_W),
        .B_W (GAIN_W)
    ) u_mul_err (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (err_reg),
        .multiplier   (ONE_Q16 - gain_reg),
        .done         (mul_err_done),
        .product      (p_err)
    );

    // Process noise times the size of the estimate change.
    ske_serial_multiplier #(
        .A_W (FIX_W),
        .B_W (Q_W)
    ) u_mul_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (q_start),
        .multiplicand (change_reg),
        .multiplier   (q_reg),
        .done         (q_done),
        .product      (p_q)
    );

    // Checks on the update sequence.
    `SKE_ASSERT_IMP(a_gain_range, (state_reg == S_MULS), (gain_reg <= ONE_Q16), "gain above one")
    `SKE_ASSERT_IMP(a_mul_pair, (mul_done || mul_err_done), (mul_done && mul_err_done && (state_reg == S_MUL)), "multipliers out of step")
    `SKE_ASSERT_IMP(a_div_done, div_done, (state_reg == S_DIV), "divider done outside divide state")
    `SKE_ASSERT_IMP(a_est_bounds, (state_reg == S_FIN), (neg_reg ? (est_reg <= last_reg && est_reg >= meas_reg) : (est_reg >= last_reg && est_reg <= meas_reg)), "estimate outside prior and measurement")
    `SKE_ASSERT_NXT(a_result_load, ((state_reg == S_FIN) && out_free), (m_tvalid_reg && (state_reg == S_IDLE)), "result beat not presented")

endmodule
